// ----- rtl/nrh_pkg.sv -----
`timescale 1ns / 1ps
// Package for the receive ring header stepper.
// Holds sizing constants, reset read page, register indices, verdict codes and result struct. No dependencies.
package nrh_pkg;

    localparam int unsigned HEADER_BYTES    = 4;
    localparam int unsigned MIN_FRAME_BYTES = 60;

    localparam logic [7:0] RESET_READ_PAGE = 8'd1;

    localparam logic [7:0] REG_RING_START = 8'd0;
    localparam logic [7:0] REG_RING_STOP  = 8'd1;

    typedef enum logic [1:0] {
        VERDICT_DELIVER  = 2'd0,
        VERDICT_TOO_BIG  = 2'd1,
        VERDICT_BAD_NEXT = 2'd2,
        VERDICT_RUNT     = 2'd3
    } verdict_t;

    typedef struct packed {
        verdict_t    verdict;
        logic [15:0] packet_size;
        logic [15:0] bytes_before_wrap;
        logic [7:0]  boundary_page;
        logic        ring_empty;
        logic [7:0]  next_read_page;
    } nrh_result_t;

endpackage

// ----- rtl/nic_receive_ring_header_step.sv -----
`timescale 1ns / 1ps
// Top level of the receive ring header stepper: input register, read page, result register.
// Depends on nrh_pkg and nrh_header_eval.

// One packet header is taken per clock cycle; each header is held in the input register and
// its result then in the result register, from which it transfers. The read page is updated in
// the same cycle the header is evaluated, so the next header sees it with no bubble. Throughput
// drops only while the result register is held by a stalled consumer. After reset the read
// page is 1; ring start and stop writes take effect on the next header and never move it.
module nic_receive_ring_header_step
    import nrh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  next_page,
    input  logic [7:0]  low_count,
    input  logic [15:0] buffer_limit,
    input  logic [7:0]  write_page,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  verdict,
    output logic [15:0] packet_size,
    output logic [15:0] bytes_before_wrap,
    output logic [7:0]  data_page,
    output logic [7:0]  boundary_page,
    output logic        ring_empty
);

    logic [7:0]  ring_start_reg;
    logic [7:0]  ring_stop_reg;
    logic [7:0]  read_page_reg;

    logic        s1_valid_reg;
    logic [7:0]  s1_next_page_reg;
    logic [7:0]  s1_low_count_reg;
    logic [15:0] s1_limit_reg;
    logic [7:0]  s1_write_page_reg;

    logic        out_valid_reg;
    verdict_t    out_verdict_reg;
    logic [15:0] out_size_reg;
    logic [15:0] out_wrap_reg;
    logic [7:0]  out_data_page_reg;
    logic [7:0]  out_bnd_reg;
    logic        out_empty_reg;

    nrh_result_t res;
    logic        advance;
    logic        in_xfer;

    assign cfg_ready = 1'b1;
    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign in_xfer   = in_valid && in_ready;

    nrh_header_eval u_eval (
        .ring_start_page (ring_start_reg),
        .ring_stop_page  (ring_stop_reg),
        .read_page       (read_page_reg),
        .next_page       (s1_next_page_reg),
        .low_count       (s1_low_count_reg),
        .buffer_limit    (s1_limit_reg),
        .write_page      (s1_write_page_reg),
        .result          (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_start_reg <= 8'd0;
            ring_stop_reg  <= 8'd255;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_RING_START)
            begin
                ring_start_reg <= cfg_data;
            end
            if (cfg_index == REG_RING_STOP)
            begin
                ring_stop_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            read_page_reg <= RESET_READ_PAGE;
        end
        else
        begin
            if (in_xfer)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                read_page_reg <= res.next_read_page;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_next_page_reg  <= next_page;
            s1_low_count_reg  <= low_count;
            s1_limit_reg      <= buffer_limit;
            s1_write_page_reg <= write_page;
        end
        if (advance)
        begin
            out_verdict_reg   <= res.verdict;
            out_size_reg      <= res.packet_size;
            out_wrap_reg      <= res.bytes_before_wrap;
            out_data_page_reg <= read_page_reg;
            out_bnd_reg       <= res.boundary_page;
            out_empty_reg     <= res.ring_empty;
        end
    end

    assign out_valid         = out_valid_reg;
    assign verdict           = out_verdict_reg;
    assign packet_size       = out_size_reg;
    assign bytes_before_wrap = out_wrap_reg;
    assign data_page         = out_data_page_reg;
    assign boundary_page     = out_bnd_reg;
    assign ring_empty        = out_empty_reg;

`ifndef ASSERT_OFF
    a_reset_verdict_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_verdict_reg == VERDICT_BAD_NEXT ||
                          out_verdict_reg == VERDICT_RUNT) |-> out_empty_reg)
        else $error("reset verdict without ring_empty");

    a_bad_next_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_verdict_reg == VERDICT_BAD_NEXT
        |-> out_size_reg == 16'd0 && out_wrap_reg == 16'd0)
        else $error("bad next page with nonzero size or wrap");

    a_wrap_in_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_wrap_reg <= out_size_reg)
        else $error("bytes_before_wrap exceeds packet_size");

    a_read_page_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (res.verdict == VERDICT_DELIVER || res.verdict == VERDICT_TOO_BIG)
        |=> read_page_reg == $past(s1_next_page_reg))
        else $error("read page did not advance to next page");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !out_ready |=> s1_valid_reg && $stable(read_page_reg))
        else $error("input stage lost while result stalled");
`endif

endmodule

// ----- rtl/nrh_header_eval.sv -----
`timescale 1ns / 1ps
// Combinational evaluation of one packet header against the ring state.
// Depends on nrh_pkg.
module nrh_header_eval
    import nrh_pkg::*;
(
    input  logic [7:0]  ring_start_page,
    input  logic [7:0]  ring_stop_page,
    input  logic [7:0]  read_page,
    input  logic [7:0]  next_page,
    input  logic [7:0]  low_count,
    input  logic [15:0] buffer_limit,
    input  logic [7:0]  write_page,
    output nrh_result_t result
);

    logic               bad_next;
    logic [8:0]         low_plus_hdr;
    logic [10:0]        over;
    logic signed [10:0] stop_m_rd;
    logic signed [10:0] nxt_m_start;
    logic signed [10:0] nxt_m_rd;
    logic               no_wrap;
    logic signed [10:0] high;
    logic signed [19:0] size;
    logic signed [19:0] wrap;
    logic [15:0]        size_sat;
    logic [15:0]        wrap_clamped;
    logic [7:0]         start_plus_one;
    logic [7:0]         advance_bnd;

    assign bad_next     = (next_page < ring_start_page) || (next_page >= ring_stop_page);
    assign low_plus_hdr = {1'b0, low_count} + 9'(HEADER_BYTES);
    assign over         = (low_plus_hdr > 9'd256) ? 11'd2 : 11'd1;

    assign stop_m_rd   = $signed({3'b000, ring_stop_page}) - $signed({3'b000, read_page});
    assign nxt_m_start = $signed({3'b000, next_page}) - $signed({3'b000, ring_start_page});
    assign nxt_m_rd    = $signed({3'b000, next_page}) - $signed({3'b000, read_page});
    assign no_wrap     = next_page > read_page;

    assign high = no_wrap ? (nxt_m_rd - $signed(over))
                          : (stop_m_rd + nxt_m_start - $signed(over));
    assign size = $signed({high[10], high, 8'h00}) + $signed({12'h000, low_count});
    assign wrap = no_wrap ? 20'sd0
                          : ($signed({stop_m_rd[10], stop_m_rd, 8'h00})
                             - $signed(20'(HEADER_BYTES)));

    assign size_sat     = (size > 20'sd65535) ? 16'hFFFF : size[15:0];
    assign wrap_clamped = (wrap < 20'sd0 || wrap > size) ? 16'd0 : wrap[15:0];

    assign start_plus_one = ring_start_page + 8'd1;
    assign advance_bnd    = (next_page == ring_start_page) ? (ring_stop_page - 8'd1)
                                                           : (next_page - 8'd1);

    always_comb
    begin
        result.verdict           = VERDICT_DELIVER;
        result.packet_size       = 16'd0;
        result.bytes_before_wrap = 16'd0;
        result.boundary_page     = advance_bnd;
        result.ring_empty        = (next_page == write_page);
        result.next_read_page    = next_page;
        priority if (bad_next)
        begin
            result.verdict        = VERDICT_BAD_NEXT;
            result.boundary_page  = ring_start_page;
            result.ring_empty     = 1'b1;
            result.next_read_page = start_plus_one;
        end
        else if (high < 11'sd0)
        begin
            result.verdict = VERDICT_TOO_BIG;
        end
        else if (size < $signed(20'(MIN_FRAME_BYTES)))
        begin
            result.verdict        = VERDICT_RUNT;
            result.packet_size    = size_sat;
            result.boundary_page  = ring_start_page;
            result.ring_empty     = 1'b1;
            result.next_read_page = start_plus_one;
        end
        else
        begin
            result.packet_size       = size_sat;
            result.bytes_before_wrap = wrap_clamped;
            result.verdict = (size <= $signed({4'h0, buffer_limit})) ? VERDICT_DELIVER
                                                                    : VERDICT_TOO_BIG;
        end
    end

endmodule
